@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the call latency tracker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/clt_pkg.sv @@
// ---------------------------------------------------------------------------
// clt_pkg
// Types and codes shared by the call latency tracker modules.
// ---------------------------------------------------------------------------
package clt_pkg;

  localparam logic [1:0] FUNC_ENTER = 2'd0;
  localparam logic [1:0] FUNC_EXIT  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] KIND_SLOW  = 2'd0;
  localparam logic [1:0] KIND_STATS = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  localparam int          THR_W     = 32;
  localparam logic [31:0] THR_RESET = 32'd1000000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] thread_id;
    logic [31:0] process_id;
    logic [63:0] timestamp_ns;
    logic [8:0]  call_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] event_process_id;
    logic [31:0] event_thread_id;
    logic [63:0] elapsed_ns;
    logic [8:0]  event_call_number;
    logic [63:0] stats_count;
    logic [63:0] stats_total_ns;
    logic [63:0] stats_max_ns;
  } out_item_t;

  typedef struct packed {
    logic [63:0] count;
    logic [63:0] total;
    logic [63:0] maximum;
  } stats_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic lookup;
    logic resolve;
    logic enter;
    logic exit_slot;
    logic update;
    logic emit_full;
    logic emit_read;
    logic emit_slow;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       hit;
    logic       free_any;
    logic       slow;
    logic       clr_last;
    logic       out_free;
  } dp_sts_t;

endpackage

@@ rtl/clt_ifs.sv @@
// ---------------------------------------------------------------------------
// clt_ifs
// Valid/ready channel interfaces for input items and result items.
// ---------------------------------------------------------------------------
interface clt_in_if;
  import clt_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clt_out_if;
  import clt_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/clt_ctrl.sv @@
// ---------------------------------------------------------------------------
// clt_ctrl
// Sequencer: clearing pass, then one item at a time through lookup steps.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module clt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output clt_pkg::ctrl_cmd_t cmd,
  input  clt_pkg::dp_sts_t   sts
);
  import clt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CAPTURE, S_RESOLVE, S_EXEC, S_SLOW
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_CAPTURE;
      end
      S_CAPTURE: begin
        cmd.lookup = 1'b1;
        state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts.func)
          FUNC_ENTER: begin
            if (sts.hit || sts.free_any) begin
              cmd.enter  = 1'b1;
              state_next = S_IDLE;
            end else if (sts.out_free) begin
              cmd.emit_full = 1'b1;
              state_next    = S_IDLE;
            end
          end
          FUNC_EXIT: begin
            if (sts.hit) begin
              cmd.exit_slot = 1'b1;
              state_next    = S_SLOW;
            end else begin
              state_next = S_IDLE;
            end
          end
          FUNC_READ: begin
            if (sts.out_free) begin
              cmd.emit_read = 1'b1;
              state_next    = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SLOW: begin
        if (!sts.slow) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.update    = 1'b1;
          cmd.emit_slow = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_one_item_at_a_time, clk, rst, in_valid && in_ready, !in_ready, "second item taken while busy")
  `ASSERT_IMPL(a_single_emit, clk, rst, 1'b1, $onehot0({cmd.emit_full, cmd.emit_read, cmd.emit_slow}), "more than one result in a cycle")
  `ASSERT_IMPL(a_emit_has_room, clk, rst, cmd.emit_full || cmd.emit_read || cmd.emit_slow, sts.out_free, "result emitted over a pending one")

endmodule

@@ rtl/clt_dp.sv @@
// ---------------------------------------------------------------------------
// clt_dp
// Datapath: start-slot table, statistics memory, duration and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module clt_dp #(
  parameter int TRACK_SLOTS  = 16,
  parameter int CALL_NUMBERS = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  input  clt_pkg::ctrl_cmd_t        cmd,
  output clt_pkg::dp_sts_t          sts,
  input  clt_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output clt_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [clt_pkg::THR_W-1:0] cfg_wdata
);
  import clt_pkg::*;

  localparam int IW  = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int SAW = (CALL_NUMBERS > 1) ? $clog2(CALL_NUMBERS) : 1;

  logic [THR_W-1:0] thr;
  in_item_t         item_q;

  // start-slot table
  logic             slot_valid [TRACK_SLOTS];
  logic [31:0]      slot_thread [TRACK_SLOTS];
  logic [63:0]      slot_start [TRACK_SLOTS];

  logic [TRACK_SLOTS-1:0] match_vec, free_vec, match_q, free_q;
  logic [IW-1:0]    hit_idx, free_idx, hit_idx_q, free_idx_q, sel_idx;
  logic             hit_q, free_any_q;
  logic [63:0]      dur_q;

  // statistics store
  stats_t           mem [CALL_NUMBERS];
  stats_t           stats_rd, mem_wdata;
  logic             mem_we;
  logic [SAW-1:0]   mem_waddr, item_addr, clr_addr;
  logic             in_range;

  logic             slow;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_q <= in_data;
  end

  // parallel tag compare, registered
  always_comb begin
    for (int i = 0; i < TRACK_SLOTS; i++) begin
      match_vec[i] = slot_valid[i] && (slot_thread[i] == item_q.thread_id);
      free_vec[i]  = !slot_valid[i];
    end
  end

  // lowest set bit wins
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TRACK_SLOTS - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = IW'(i);
      if (free_q[i])  free_idx = IW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      match_q <= match_vec;
      free_q  <= free_vec;
    end
    if (cmd.resolve) begin
      hit_q      <= |match_q;
      free_any_q <= |free_q;
      hit_idx_q  <= hit_idx;
      free_idx_q <= free_idx;
    end
    if (cmd.exit_slot) dur_q <= item_q.timestamp_ns - slot_start[hit_idx_q];
  end

  assign sel_idx = hit_q ? hit_idx_q : free_idx_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACK_SLOTS; i++) slot_valid[i] <= 1'b0;
    end else if (cmd.enter) begin
      slot_valid[sel_idx] <= 1'b1;
    end else if (cmd.exit_slot) begin
      slot_valid[hit_idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enter) begin
      slot_thread[sel_idx] <= item_q.thread_id;
      slot_start[sel_idx]  <= item_q.timestamp_ns;
    end
  end

  // statistics memory: one write, one registered read
  assign item_addr = SAW'(item_q.call_number);
  assign in_range  = (32'(item_q.call_number) < 32'(CALL_NUMBERS));

  always_comb begin
    mem_we    = cmd.clear || (cmd.update && in_range);
    mem_waddr = cmd.clear ? clr_addr : item_addr;
    if (cmd.clear) begin
      mem_wdata = '0;
    end else begin
      mem_wdata.count   = stats_rd.count + 64'd1;
      mem_wdata.total   = stats_rd.total + dur_q;
      mem_wdata.maximum = (dur_q > stats_rd.maximum) ? dur_q : stats_rd.maximum;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.lookup) stats_rd <= mem[item_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + SAW'(1);
    end
  end

  assign slow = (dur_q > {32'd0, thr});

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_full || cmd.emit_read || cmd.emit_slow) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_full) begin
      out_data                 <= '0;
      out_data.kind            <= KIND_FULL;
      out_data.event_thread_id <= item_q.thread_id;
    end else if (cmd.emit_read) begin
      out_data                   <= '0;
      out_data.kind              <= KIND_STATS;
      out_data.event_call_number <= item_q.call_number;
      if (in_range) begin
        out_data.stats_count    <= stats_rd.count;
        out_data.stats_total_ns <= stats_rd.total;
        out_data.stats_max_ns   <= stats_rd.maximum;
      end
    end else if (cmd.emit_slow) begin
      out_data                   <= '0;
      out_data.kind              <= KIND_SLOW;
      out_data.event_process_id  <= item_q.process_id;
      out_data.event_thread_id   <= item_q.thread_id;
      out_data.elapsed_ns        <= dur_q;
      out_data.event_call_number <= item_q.call_number;
    end
  end

  assign sts.func     = item_q.func;
  assign sts.hit      = hit_q;
  assign sts.free_any = free_any_q;
  assign sts.slow     = slow;
  assign sts.clr_last = (clr_addr == SAW'(CALL_NUMBERS - 1));
  assign sts.out_free = !out_valid || out_ready;

  `ASSERT_NEXT(a_enter_takes_slot, clk, rst, cmd.enter, slot_valid[$past(sel_idx)], "enter left its slot empty")
  `ASSERT_NEXT(a_exit_frees_slot, clk, rst, cmd.exit_slot, !slot_valid[$past(hit_idx_q)], "exit did not free its slot")

endmodule

@@ rtl/call_latency_tracker_top.sv @@
// ---------------------------------------------------------------------------
// call_latency_tracker_top
// Call latency tracker: start-time table per thread and slow-call statistics.
// ---------------------------------------------------------------------------
// After reset the block zeroes every entry of its statistics memory
// (item.ready low; threshold writes are still taken). Then it handles one
// item at a time: an accepted item is followed by a tag-compare state, a
// priority-select state and an execute state, and an exit that finds its
// thread also passes a slow-check state before the next item is accepted.
// These steps are set by the registered tag compare and lowest-slot search
// over the start table and by the single read port of the statistics memory.
// A result sits in an output register, so the next item is accepted while
// it waits; only a new result blocks until the previous one has been
// transferred.
module call_latency_tracker_top #(
  parameter int TRACK_SLOTS  = 16,
  parameter int CALL_NUMBERS = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  clt_in_if.sink                    item,
  clt_out_if.source                 result,
  input  logic                      cfg_we,
  input  logic [clt_pkg::THR_W-1:0] cfg_wdata
);
  import clt_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer: owns the only state machine
  clt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // slot table, statistics memory and result register
  clt_dp #(
    .TRACK_SLOTS  (TRACK_SLOTS),
    .CALL_NUMBERS (CALL_NUMBERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (item.data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

@@ verif/tb_call_latency_tracker_top.sv @@
// ---------------------------------------------------------------------------
// tb_call_latency_tracker_top
// Self-checking bench for the call latency tracker. Enter, exit, read and
// unused items go in as valid/ready transfers in random bursts. A board keeps
// its own start table and slow-call statistics and predicts every report. The
// result side stalls on a random pattern, with long hold-offs in some phases.
// The threshold is changed between phases while the block is quiet.
// ---------------------------------------------------------------------------
import clt_pkg::*;

class call_latency_board;
  localparam int SLOTS = 16;
  localparam int CALLS = 512;

  logic [31:0] threshold;
  bit          slot_used  [SLOTS];
  logic [31:0] slot_tid   [SLOTS];
  logic [63:0] slot_start [SLOTS];
  logic [63:0] slow_count [CALLS];
  logic [63:0] slow_total [CALLS];
  logic [63:0] slow_peak  [CALLS];
  out_item_t   pending_reports[$];

  int mismatches;
  int enters, exits, reads, ignored;
  int slow_events, readouts, full_reports;

  function new();
    threshold = THR_RESET;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    foreach (slow_count[i]) begin
      slow_count[i] = '0;
      slow_total[i] = '0;
      slow_peak[i]  = '0;
    end
  endfunction

  function int pending();
    return pending_reports.size();
  endfunction

  // Update the tables for one accepted item and queue the report it causes.
  function void record_call(in_item_t it);
    out_item_t   rep;
    int          hit;
    int          spare;
    logic [63:0] dur;
    rep   = '0;
    hit   = -1;
    spare = -1;
    // descending scan leaves the lowest free slot in spare
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_tid[i] == it.thread_id) hit = i;
      if (!slot_used[i]) spare = i;
    end
    case (it.func)
      FUNC_ENTER: begin
        enters++;
        if (hit < 0) hit = spare;
        if (hit < 0) begin
          rep.kind            = KIND_FULL;
          rep.event_thread_id = it.thread_id;
          pending_reports.push_back(rep);
        end else begin
          slot_used[hit]  = 1'b1;
          slot_tid[hit]   = it.thread_id;
          slot_start[hit] = it.timestamp_ns;
        end
      end
      FUNC_EXIT: begin
        exits++;
        if (hit >= 0) begin
          dur = it.timestamp_ns - slot_start[hit];
          slot_used[hit] = 1'b0;
          if (dur > {32'd0, threshold}) begin
            if (it.call_number < CALLS) begin
              slow_count[it.call_number] += 64'd1;
              slow_total[it.call_number] += dur;
              if (dur > slow_peak[it.call_number]) slow_peak[it.call_number] = dur;
            end
            rep.kind              = KIND_SLOW;
            rep.event_process_id  = it.process_id;
            rep.event_thread_id   = it.thread_id;
            rep.elapsed_ns        = dur;
            rep.event_call_number = it.call_number;
            pending_reports.push_back(rep);
          end
        end
      end
      FUNC_READ: begin
        reads++;
        rep.kind              = KIND_STATS;
        rep.event_call_number = it.call_number;
        if (it.call_number < CALLS) begin
          rep.stats_count    = slow_count[it.call_number];
          rep.stats_total_ns = slow_total[it.call_number];
          rep.stats_max_ns   = slow_peak[it.call_number];
        end
        pending_reports.push_back(rep);
      end
      default: ignored++;
    endcase
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  function void check_report(out_item_t got);
    out_item_t want;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected report: kind %0d thread %0h", got.kind, got.event_thread_id);
      return;
    end
    want = pending_reports.pop_front();
    case (want.kind)
      KIND_SLOW:  slow_events++;
      KIND_STATS: readouts++;
      default:    full_reports++;
    endcase
    compare_field("kind", 64'(want.kind), 64'(got.kind));
    compare_field("event_process_id", 64'(want.event_process_id),
                  64'(got.event_process_id));
    compare_field("event_thread_id", 64'(want.event_thread_id),
                  64'(got.event_thread_id));
    compare_field("elapsed_ns", want.elapsed_ns, got.elapsed_ns);
    compare_field("event_call_number", 64'(want.event_call_number),
                  64'(got.event_call_number));
    compare_field("stats_count", want.stats_count, got.stats_count);
    compare_field("stats_total_ns", want.stats_total_ns, got.stats_total_ns);
    compare_field("stats_max_ns", want.stats_max_ns, got.stats_max_ns);
  endfunction
endclass

module tb_call_latency_tracker_top;

  localparam int TRACK_SLOTS    = 16;
  localparam int CALL_NUMBERS   = 512;
  // time for one item to pass through the block, with a margin
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 262;
  localparam int HOLDOFF_CYCLES = 400;
  // func code that the block must ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  clt_in_if  item_ch ();
  clt_out_if result_ch ();

  call_latency_board board = new();

  // Stimulus-side view of open calls, kept apart from the board so that the
  // generator never depends on the order of processes within an edge. It can
  // drift from the block (rejected enters, stray exits); that only turns a
  // later exit into a dropped one.
  logic [31:0] slow_limit;
  logic [63:0] now_ns;
  logic [63:0] started [bit [31:0]];
  logic [31:0] open_calls[$];
  logic [31:0] id_pool[$];
  int          pool_size;
  int          holdoff_req;
  int          settings_used;

  call_latency_tracker_top #(
    .TRACK_SLOTS  (TRACK_SLOTS),
    .CALL_NUMBERS (CALL_NUMBERS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor: every signal here was last changed by a nonblocking update, so
  // at the edge we see the values that the block itself sampled. A result
  // transferred at this edge always belongs to an earlier item, so it is
  // checked before the item transferred at the same edge is recorded.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) board.check_report(result_ch.data);
      if (item_ch.valid && item_ch.ready) board.record_call(item_ch.data);
    end
  end

  // ---- stimulus helpers ---------------------------------------------------

  function automatic in_item_t call_item(logic [1:0] f, logic [31:0] tid,
                                         logic [31:0] pid, logic [63:0] ts,
                                         logic [8:0] cn);
    in_item_t it;
    it.func         = f;
    it.thread_id    = tid;
    it.process_id   = pid;
    it.timestamp_ns = ts;
    it.call_number  = cn;
    return it;
  endfunction

  function automatic void note_enter(logic [31:0] tid, logic [63:0] ts);
    if (!started.exists(tid)) open_calls.push_back(tid);
    started[tid] = ts;
  endfunction

  function automatic void note_exit(logic [31:0] tid);
    for (int i = open_calls.size() - 1; i >= 0; i--)
      if (open_calls[i] == tid) open_calls.delete(i);
    started.delete(tid);
  endfunction

  // Call duration around the current threshold: at it, just over it, well
  // under, well over, and wrapped (exit stamp behind the start stamp).
  function automatic logic [63:0] exit_delay();
    logic [63:0] lim;
    lim = {32'd0, slow_limit};
    case ($urandom_range(0, 9))
      0:       return lim;
      1:       return lim + 64'd1;
      2, 3:    return {$urandom, $urandom} % (lim + 64'd1);
      4:       return 64'd0;
      8:       return {$urandom, $urandom};
      9:       return 64'd0 - 64'($urandom_range(1, 1000));
      default: return lim + 64'd1 + 64'($urandom_range(0, 5000));
    endcase
  endfunction

  function automatic logic [31:0] pick_thread();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return id_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  // Mostly a handful of call numbers so statistics pile up (and totals wrap)
  function automatic logic [8:0] pick_call_number();
    case ($urandom_range(0, 9))
      0, 1:    return 9'($urandom_range(0, 511));
      2:       return 9'd511;
      default: return 9'($urandom_range(0, 7));
    endcase
  endfunction

  // Mostly matched enter/exit pairs on a pool of threads, plus reads, stray
  // exits and unused codes.
  function automatic in_item_t next_call_item();
    in_item_t    it;
    int          r;
    int          k;
    logic [31:0] tid;
    logic [63:0] ts;
    r  = $urandom_range(0, 99);
    it = call_item(FUNC_READ, $urandom, $urandom, {$urandom, $urandom}, pick_call_number());
    if (r < 42) begin
      tid = pick_thread();
      ts  = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : now_ns;
      now_ns += 64'($urandom_range(1, 2000));
      note_enter(tid, ts);
      it.func         = FUNC_ENTER;
      it.thread_id    = tid;
      it.timestamp_ns = ts;
    end else if (r < 84) begin
      it.func = FUNC_EXIT;
      if (open_calls.size() > 0 && $urandom_range(0, 9) != 0) begin
        k   = $urandom_range(0, open_calls.size() - 1);
        tid = open_calls[k];
        it.thread_id    = tid;
        it.timestamp_ns = started[tid] + exit_delay();
        note_exit(tid);
      end else begin
        it.thread_id    = pick_thread();
        it.timestamp_ns = now_ns;
      end
    end else if (r >= 96) begin
      it.func = FUNC_UNUSED;
    end
    return it;
  endfunction

  // ---- drivers ------------------------------------------------------------

  // Offer one item and hold it until the transfer. valid stays high on exit,
  // so back-to-back items see a single update of valid per edge.
  task automatic push_item(input in_item_t it);
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic end_burst(input int gap);
    item_ch.valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic run_traffic(input int n_items, input bit no_gaps);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        push_item(next_call_item());
        sent++;
      end
      if (!no_gaps && $urandom_range(0, 3) != 0) end_burst($urandom_range(1, 8));
    end
    end_burst(1);
  endtask

  // All reports in, then give a silent item time to leave the pipeline
  task automatic wait_quiet();
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.threshold = v;
    slow_limit      = v;
    settings_used++;
  endtask

  // Directed opening, under the reset threshold: empty readout, re-enter of a
  // live thread, exit exactly at the threshold, exit of an unknown thread,
  // wrapped duration with all-ones ids and top call number, the unused code,
  // then fill the start table and overflow it.
  task automatic run_directed();
    logic [31:0] fill_id;
    push_item(call_item(FUNC_READ, '0, '0, '0, 9'd0));
    note_enter(32'd0, 64'd0);
    push_item(call_item(FUNC_ENTER, 32'd0, 32'd0, 64'd0, 9'd0));
    note_enter(32'd0, 64'd5);
    push_item(call_item(FUNC_ENTER, 32'd0, 32'd0, 64'd5, 9'd0));
    note_exit(32'd0);
    push_item(call_item(FUNC_EXIT, 32'd0, 32'd0, 64'd5 + 64'(THR_RESET), 9'd0));
    push_item(call_item(FUNC_EXIT, 32'd0, 32'd0, '1, 9'd0));
    note_enter('1, 64'hFFFF_FFFF_FFFF_FFF6);
    push_item(call_item(FUNC_ENTER, '1, '1, 64'hFFFF_FFFF_FFFF_FFF6, 9'd511));
    note_exit('1);
    push_item(call_item(FUNC_EXIT, '1, '1, 64'd1000000, 9'd511));
    push_item(call_item(FUNC_READ, '1, '1, '1, 9'd511));
    push_item(call_item(FUNC_UNUSED, '1, '1, '1, '1));
    for (int i = 0; i <= TRACK_SLOTS; i++) begin
      fill_id = $urandom;
      note_enter(fill_id, now_ns);
      push_item(call_item(FUNC_ENTER, fill_id, $urandom, now_ns, pick_call_number()));
      now_ns += 64'd10;
    end
    end_burst(1);
  endtask

  // ---- result side --------------------------------------------------------

  // ready follows a 16-bit mask, redrawn once all its bits are used: wide open,
  // random, mostly open, fully stalled or a fixed stripe. A hold-off request from
  // the stimulus makes it refuse every transfer for the requested hold-off.
  initial begin : result_sink
    logic [15:0] stall_mask;
    int          mask_bit;
    int          hold_n;
    result_ch.ready <= 1'b0;
    stall_mask = '1;
    mask_bit   = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req > 0) begin
        hold_n      = holdoff_req;
        holdoff_req = 0;
        result_ch.ready <= 1'b0;
        repeat (hold_n) @(posedge clk);
      end else begin
        if (mask_bit == 0) begin
          case ($urandom_range(0, 5))
            0, 1:    stall_mask = '1;
            2:       stall_mask = 16'($urandom);
            3:       stall_mask = 16'($urandom | $urandom);
            4:       stall_mask = '0;
            default: stall_mask = 16'h3333;
          endcase
        end
        result_ch.ready <= stall_mask[mask_bit];
        mask_bit = (mask_bit + 1) % 16;
      end
    end
  end

  // ---- run ----------------------------------------------------------------

  initial begin : stimulus
    logic [31:0] limits [RANDOM_PHASES];
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    slow_limit    = THR_RESET;
    now_ns        = '0;
    holdoff_req   = 0;
    settings_used = 1;
    pool_size     = 10;
    repeat (32) id_pool.push_back($urandom);
    // reset value first, then both extremes and a few in between
    limits = '{THR_RESET, 32'd0, 32'hFFFF_FFFF, $urandom, $urandom_range(1, 50),
               $urandom_range(0, 2000000)};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // the block clears its statistics first; push_item just waits for ready
    run_directed();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_quiet();
      if (p > 0) write_threshold(limits[p]);
      // small pool keeps the table partly free, large pool overflows it
      pool_size = (p % 2 == 0) ? 10 : 28;
      // long receiver hold-off: results back up and the input stalls
      if (p == 2 || p == 4) holdoff_req = HOLDOFF_CYCLES;
      run_traffic(PHASE_ITEMS, p == 3);
    end
    wait_quiet();

    $display("Covered %0d transfers in: %0d enter, %0d exit, %0d read, %0d ignored; %0d thresholds",
             board.enters + board.exits + board.reads + board.ignored, board.enters,
             board.exits, board.reads, board.ignored, settings_used);
    $display("Reports checked: %0d slow calls, %0d readouts, %0d table full; %0d mismatches",
             board.slow_events, board.readouts, board.full_reports, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("call_latency_tracker_top regression: pass");
    end else begin
      if (board.pending() != 0)
        $display("%0d expected reports never arrived", board.pending());
      $display("call_latency_tracker_top regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including the clearing pass
  initial begin : watchdog
    #1500000;
    $display("call_latency_tracker_top regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/clt_pkg.sv
rtl/clt_ifs.sv
rtl/clt_ctrl.sv
rtl/clt_dp.sv
rtl/call_latency_tracker_top.sv
verif/tb_call_latency_tracker_top.sv
